// ===== src/mmbs_pkg.sv =====
`default_nettype none
package mmbs_pkg;

    localparam int MAX_PIXELS = 65536;
    localparam int WINDOW     = 20;
    localparam int HIST_SLOTS = WINDOW - 1;

    localparam int SAMPLE_W = 8;
    localparam int POS_W    = $clog2(MAX_PIXELS);
    localparam int FSIZE_W  = POS_W + 1;
    localparam int SLOT_W   = $clog2(HIST_SLOTS + 1);
    localparam int SUM_W    = 13;
    localparam int T_W      = SUM_W + 1;

    // history is addressed as {slot, pos}; MAX_PIXELS is a power of two
    localparam int HIST_DEPTH = HIST_SLOTS * MAX_PIXELS;
    localparam int HIST_AW    = SLOT_W + POS_W;

    localparam int HALF_WINDOW = WINDOW / 2;

    // t / WINDOW as (t * RECIP) >> RECIP_SHIFT, exact for t < 2**T_W
    localparam int RECIP_SHIFT = 17;
    localparam int RECIP       = (2 ** RECIP_SHIFT + WINDOW - 1) / WINDOW;
    localparam int RECIP_W     = $clog2(RECIP + 1);
    localparam int PROD_W      = T_W + RECIP_W;
    localparam int BG_W        = PROD_W - RECIP_SHIFT;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [SLOT_W-1:0] slot;
        logic              warm;
        logic              sum_ok;
    } t_pix_ctl;

endpackage
`default_nettype wire

// ===== src/mmbs_seq.sv =====
`default_nettype none
module mmbs_seq (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_wr_en,
    input  wire  [mmbs_pkg::FSIZE_W-1:0] i_cfg_wr_data,
    input  wire                          i_accept,
    output mmbs_pkg::t_pix_ctl           o_ctl
);
    import mmbs_pkg::*;

    logic [FSIZE_W-1:0] r_frame_pixels;
    logic [POS_W-1:0]   r_pos;
    logic [SLOT_W-1:0]  r_slot;
    logic [SLOT_W-1:0]  r_frames;
    logic [FSIZE_W-1:0] r_fill;

    logic [FSIZE_W-1:0] fsize;
    logic [FSIZE_W-1:0] pos_inc;
    logic               wrap;
    logic               warm;

    always_comb begin
        if (r_frame_pixels == '0 || r_frame_pixels > FSIZE_W'(MAX_PIXELS)) begin
            fsize = FSIZE_W'(MAX_PIXELS);
        end else begin
            fsize = r_frame_pixels;
        end
        pos_inc = {1'b0, r_pos} + FSIZE_W'(1);
        wrap    = pos_inc >= fsize;
        warm    = r_frames < SLOT_W'(HIST_SLOTS);
    end

    assign o_ctl.pos    = r_pos;
    assign o_ctl.slot   = r_slot;
    assign o_ctl.warm   = warm;
    assign o_ctl.sum_ok = {1'b0, r_pos} < r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_pixels <= FSIZE_W'(MAX_PIXELS);
            r_pos          <= '0;
            r_slot         <= '0;
            r_frames       <= '0;
            r_fill         <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_frame_pixels <= i_cfg_wr_data;
            end
            if (i_accept) begin
                if (pos_inc > r_fill) begin
                    r_fill <= pos_inc;
                end
                if (wrap) begin
                    r_pos <= '0;
                    if (warm) begin
                        r_frames <= r_frames + SLOT_W'(1);
                    end
                    if (r_slot == SLOT_W'(HIST_SLOTS - 1)) begin
                        r_slot <= '0;
                    end else begin
                        r_slot <= r_slot + SLOT_W'(1);
                    end
                end else begin
                    r_pos <= pos_inc[POS_W-1:0];
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/mmbs_store.sv =====
`default_nettype none
module mmbs_store (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_accept,
    input  wire  [mmbs_pkg::SAMPLE_W-1:0] i_sample,
    input  mmbs_pkg::t_pix_ctl            i_ctl,
    output logic                          o_ready,
    output logic                          o_valid,
    input  wire                           i_ready,
    output logic [mmbs_pkg::T_W-1:0]      o_total,
    output logic [mmbs_pkg::SAMPLE_W-1:0] o_sample,
    output logic                          o_warm
);
    import mmbs_pkg::*;

    logic [SAMPLE_W-1:0] hist_mem [HIST_DEPTH];
    logic [SUM_W-1:0]    sum_mem  [MAX_PIXELS];

    logic                r_s1_v;
    logic [POS_W-1:0]    r_s1_pos;
    logic [SAMPLE_W-1:0] r_s1_sample;
    logic                r_s1_warm;
    logic                r_s1_sum_ok;
    logic [SUM_W-1:0]    r_s1_sum_rd;
    logic [SAMPLE_W-1:0] r_s1_old;
    logic                r_s1_fwd;
    logic [SUM_W-1:0]    r_s1_fwd_sum;

    logic [SUM_W-1:0]    sum_cur;
    logic [SUM_W-1:0]    n_sum;
    logic                leave;

    assign o_ready = !r_s1_v || i_ready;
    assign leave   = r_s1_v && i_ready;

    always_comb begin
        if (r_s1_fwd) begin
            sum_cur = r_s1_fwd_sum;
        end else if (r_s1_sum_ok) begin
            sum_cur = r_s1_sum_rd;
        end else begin
            sum_cur = '0;
        end
        if (r_s1_warm) begin
            n_sum = sum_cur + SUM_W'(r_s1_sample);
        end else begin
            n_sum = sum_cur + SUM_W'(r_s1_sample) - SUM_W'(r_s1_old);
        end
    end

    assign o_valid  = r_s1_v;
    assign o_total  = {1'b0, sum_cur} + T_W'(r_s1_sample) + T_W'(HALF_WINDOW);
    assign o_sample = r_s1_sample;
    assign o_warm   = r_s1_warm;

    // read before write: the old history entry comes out as the new one goes in
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_old <= hist_mem[{i_ctl.slot, i_ctl.pos}];
            hist_mem[{i_ctl.slot, i_ctl.pos}] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_sum_rd <= sum_mem[i_ctl.pos];
        end
        if (leave) begin
            sum_mem[r_s1_pos] <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_pos     <= i_ctl.pos;
            r_s1_sample  <= i_sample;
            r_s1_warm    <= i_ctl.warm;
            r_s1_sum_ok  <= i_ctl.sum_ok;
            r_s1_fwd     <= r_s1_v && (r_s1_pos == i_ctl.pos);
            r_s1_fwd_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (o_ready) begin
            r_s1_v <= i_accept;
        end
    end

endmodule
`default_nettype wire

// ===== src/mmbs_diff.sv =====
`default_nettype none
module mmbs_diff (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_ready,
    input  wire  [mmbs_pkg::T_W-1:0]      i_total,
    input  wire  [mmbs_pkg::SAMPLE_W-1:0] i_sample,
    input  wire                           i_warm,
    output logic                          o_valid,
    input  wire                           i_ready,
    output logic [mmbs_pkg::SAMPLE_W-1:0] o_difference,
    output logic                          o_warming_up
);
    import mmbs_pkg::*;

    logic                r_s2_v;
    logic [T_W-1:0]      r_s2_total;
    logic [SAMPLE_W-1:0] r_s2_sample;
    logic                r_s2_warm;

    logic                r_s3_v;
    logic [PROD_W-1:0]   r_s3_prod;
    logic [SAMPLE_W-1:0] r_s3_sample;
    logic                r_s3_warm;

    logic                r_out_v;
    logic [SAMPLE_W-1:0] r_out_diff;
    logic                r_out_warm;

    logic                out_en;
    logic                s3_en;
    logic                s2_en;
    logic [BG_W-1:0]     bg_wide;
    logic [SAMPLE_W-1:0] bg;
    logic [SAMPLE_W-1:0] n_diff;

    assign out_en  = !r_out_v || i_ready;
    assign s3_en   = !r_s3_v || out_en;
    assign s2_en   = !r_s2_v || s3_en;
    assign o_ready = s2_en;

    always_comb begin
        bg_wide = r_s3_prod[PROD_W-1:RECIP_SHIFT];
        if (bg_wide > BG_W'(SAMPLE_MAX)) begin
            bg = SAMPLE_MAX;
        end else begin
            bg = bg_wide[SAMPLE_W-1:0];
        end
        if (r_s3_warm) begin
            n_diff = r_s3_sample;
        end else if (r_s3_sample >= bg) begin
            n_diff = r_s3_sample - bg;
        end else begin
            n_diff = bg - r_s3_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_en) begin
            r_s2_total  <= i_total;
            r_s2_sample <= i_sample;
            r_s2_warm   <= i_warm;
        end
        if (s3_en) begin
            r_s3_prod   <= PROD_W'(r_s2_total) * PROD_W'(RECIP);
            r_s3_sample <= r_s2_sample;
            r_s3_warm   <= r_s2_warm;
        end
        if (out_en) begin
            r_out_diff <= n_diff;
            r_out_warm <= r_s3_warm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (s2_en) begin
                r_s2_v <= i_valid;
            end
            if (s3_en) begin
                r_s3_v <= r_s2_v;
            end
            if (out_en) begin
                r_out_v <= r_s3_v;
            end
        end
    end

    assign o_valid      = r_out_v;
    assign o_difference = r_out_diff;
    assign o_warming_up = r_out_warm;

endmodule
`default_nettype wire

// ===== src/moving_mean_background_subtract_unit.sv =====
// Moving-mean background subtraction, one 8-bit sample per item.
// Input channel: i_in_valid / o_in_ready with i_sample, raster order,
// frame after frame. Output channel: o_out_valid / i_out_ready with
// o_difference (|sample - background|) and o_warming_up.
// i_cfg_wr_en / i_cfg_wr_data set the frame size in samples (1..65536;
// 0 or larger values mean 65536); write it only while the block is idle.
// The accepted sample passes the store stage register, then the s2, s3 and
// output registers, before o_out_valid rises. Throughput is one item per
// cycle while i_out_ready stays high; the per-pixel sum memory is read on
// entry, written back one stage later, bypassed for a repeated position.
// The background is the rounded mean of the sample and the same pixel of
// the last 19 frames; for the first 19 frames the sample is passed through
// with o_warming_up high.
// Reset (i_rst_n low, synchronous) clears the pipeline, the position and
// frame counters and the sum fill count; no memory clearing pass is needed.
// A stalled receiver holds the output register; stages behind it fill any
// bubbles, then o_in_ready drops.
`default_nettype none
module moving_mean_background_subtract_unit (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_wr_en,
    input  wire  [mmbs_pkg::FSIZE_W-1:0]  i_cfg_wr_data,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire  [mmbs_pkg::SAMPLE_W-1:0] i_sample,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic [mmbs_pkg::SAMPLE_W-1:0] o_difference,
    output logic                          o_warming_up
);
    import mmbs_pkg::*;

    t_pix_ctl            ctl;
    logic                accept;
    logic                st_valid;
    logic                st_ready;
    logic [T_W-1:0]      st_total;
    logic [SAMPLE_W-1:0] st_sample;
    logic                st_warm;

    assign accept = i_in_valid && o_in_ready;

    mmbs_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .o_ctl         (ctl)
    );

    mmbs_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_sample (i_sample),
        .i_ctl    (ctl),
        .o_ready  (o_in_ready),
        .o_valid  (st_valid),
        .i_ready  (st_ready),
        .o_total  (st_total),
        .o_sample (st_sample),
        .o_warm   (st_warm)
    );

    mmbs_diff u_diff (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (st_valid),
        .o_ready      (st_ready),
        .i_total      (st_total),
        .i_sample     (st_sample),
        .i_warm       (st_warm),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_difference (o_difference),
        .o_warming_up (o_warming_up)
    );

endmodule
`default_nettype wire
